### sv/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/kl_pkg.sv
// ---------------------------------------------------------------------------
// kl_pkg
// types, codes and character helpers for the keyword lexer
// ---------------------------------------------------------------------------
package kl_pkg;

  localparam int POS_WIDTH   = 16;
  localparam int OUT_POS_W   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_STR,
    MODE_OP
  } mode_t;

  typedef enum logic [2:0] {
    CC_TEXT,
    CC_SPACE,
    CC_DIGIT,
    CC_QUOTE,
    CC_OPSYM,
    CC_SINGLE,
    CC_BAD
  } char_class_t;

  typedef enum logic [3:0] {
    TOK_IF        = 4'd0,
    TOK_THEN      = 4'd1,
    TOK_ELSE      = 4'd2,
    TOK_LET       = 4'd3,
    TOK_IN        = 4'd4,
    TOK_FIX       = 4'd5,
    TOK_IDENT     = 4'd6,
    TOK_STRING    = 4'd7,
    TOK_INTEGER   = 4'd8,
    TOK_ERROR     = 4'd9,
    TOK_END       = 4'd10,
    TOK_BACKSLASH = 4'd11,
    TOK_EQUAL     = 4'd12,
    TOK_DOT       = 4'd13,
    TOK_LPAREN    = 4'd14,
    TOK_RPAREN    = 4'd15
  } tok_kind_t;

  // input kind codes
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // keyword and operator patterns, right aligned
  localparam logic [31:0] KW_IF   = 32'("if");
  localparam logic [31:0] KW_THEN = 32'("then");
  localparam logic [31:0] KW_ELSE = 32'("else");
  localparam logic [31:0] KW_LET  = 32'("let");
  localparam logic [31:0] KW_IN   = 32'("in");
  localparam logic [31:0] KW_FIX  = 32'("fix");
  localparam logic [15:0] OP_COLONS   = 16'("::");
  localparam logic [15:0] OP_BRACKETS = 16'("[]");

  typedef struct packed {
    tok_kind_t              kind;
    logic [OUT_POS_W-1:0]   start_pos;
    logic [OUT_POS_W-1:0]   end_pos;
  } token_t;

  // results of one input item: one or two tokens
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } group_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cls;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") cls = CC_TEXT;
    else if (c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09) cls = CC_SPACE;
    else if (c >= "0" && c <= "9") cls = CC_DIGIT;
    else if (c == 8'h22 || c == 8'h27) cls = CC_QUOTE;
    else if (c == "[" || c == "]" || c == ":") cls = CC_OPSYM;
    else if (c == 8'h5c || c == "=" || c == "." || c == "(" || c == ")") cls = CC_SINGLE;
    else cls = CC_BAD;
    return cls;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    return r;
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] c);
    tok_kind_t k;
    if (c == 8'h5c) k = TOK_BACKSLASH;
    else if (c == "=") k = TOK_EQUAL;
    else if (c == ".") k = TOK_DOT;
    else if (c == "(") k = TOK_LPAREN;
    else k = TOK_RPAREN;
    return k;
  endfunction

  function automatic tok_kind_t word_kind(input logic [31:0] w, input logic [2:0] len);
    tok_kind_t k;
    if (len == 3'd2 && w == KW_IF) k = TOK_IF;
    else if (len == 3'd4 && w == KW_THEN) k = TOK_THEN;
    else if (len == 3'd4 && w == KW_ELSE) k = TOK_ELSE;
    else if (len == 3'd3 && w == KW_LET) k = TOK_LET;
    else if (len == 3'd2 && w == KW_IN) k = TOK_IN;
    else if (len == 3'd3 && w == KW_FIX) k = TOK_FIX;
    else k = TOK_IDENT;
    return k;
  endfunction

endpackage

### sv/kl_if.sv
// ---------------------------------------------------------------------------
// kl_if
// byte and token channels of the keyword lexer
// ---------------------------------------------------------------------------
interface kl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, kind, char_code, input ready);
  modport sink (input valid, kind, char_code, output ready);
endinterface

interface kl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] end_pos;
  logic        last_of_run;

  modport source (output valid, token_kind, start_pos, end_pos, last_of_run, input ready);
  modport sink (input valid, token_kind, start_pos, end_pos, last_of_run, output ready);
endinterface

### sv/kl_front.sv
// ---------------------------------------------------------------------------
// kl_front
// byte classification, lexer state and token group assembly
// ---------------------------------------------------------------------------
module kl_front (
  input  logic            clk,
  input  logic            rst,
  kl_in_if.sink           text,
  input  logic            q_full,
  output logic            push,
  output kl_pkg::group_t  grp
);

  logic [kl_pkg::POS_WIDTH-1:0] pos, pos_next, pos_inc;
  logic [kl_pkg::POS_WIDTH-1:0] tok_start, tok_start_next;
  kl_pkg::mode_t                mode, mode_next;
  logic [31:0]                  kw_chars, kw_chars_next;
  logic [2:0]                   id_len, id_len_next;
  logic [15:0]                  op_chars, op_chars_next;
  logic [1:0]                   op_len, op_len_next;

  logic                  accept, is_end;
  kl_pkg::char_class_t   cls;
  logic [7:0]            lc;
  logic                  in_str, ext_ident, ext_num, ext_op;
  logic                  flush_valid, op_ok;
  kl_pkg::token_t        flush_tok, first_tok, new_tok;
  logic                  has_first, has_new;

  assign text.ready = !q_full;
  assign accept     = text.valid && text.ready;
  assign is_end     = (text.kind == kl_pkg::KIND_END);
  assign cls        = kl_pkg::classify(text.char_code);
  assign lc         = kl_pkg::to_lower(text.char_code);
  assign pos_inc    = (&pos) ? pos : pos + 1'b1;

  assign in_str    = (mode == kl_pkg::MODE_STR);
  assign ext_ident = (mode == kl_pkg::MODE_IDENT) &&
                     (cls == kl_pkg::CC_TEXT || cls == kl_pkg::CC_DIGIT);
  assign ext_num   = (mode == kl_pkg::MODE_NUM) && (cls == kl_pkg::CC_DIGIT);
  assign ext_op    = (mode == kl_pkg::MODE_OP) && (cls == kl_pkg::CC_OPSYM);

  assign flush_valid = (mode == kl_pkg::MODE_IDENT) || (mode == kl_pkg::MODE_NUM) ||
                       (mode == kl_pkg::MODE_OP);
  assign op_ok = (op_len == 2'd2) &&
                 (op_chars == kl_pkg::OP_COLONS || op_chars == kl_pkg::OP_BRACKETS);

  // pending token closed at the current offset
  always_comb begin
    flush_tok.start_pos = kl_pkg::OUT_POS_W'(tok_start);
    flush_tok.end_pos   = kl_pkg::OUT_POS_W'(pos);
    case (mode)
      kl_pkg::MODE_IDENT: flush_tok.kind = kl_pkg::word_kind(kw_chars, id_len);
      kl_pkg::MODE_NUM:   flush_tok.kind = kl_pkg::TOK_INTEGER;
      kl_pkg::MODE_OP:    flush_tok.kind = op_ok ? kl_pkg::TOK_IDENT : kl_pkg::TOK_ERROR;
      default:            flush_tok.kind = kl_pkg::TOK_ERROR;
    endcase
  end

  // outputs: tokens caused by the current byte
  always_comb begin
    has_first = 1'b0;
    has_new   = 1'b0;
    first_tok = flush_tok;
    new_tok.kind      = kl_pkg::TOK_ERROR;
    new_tok.start_pos = kl_pkg::OUT_POS_W'(pos);
    new_tok.end_pos   = kl_pkg::OUT_POS_W'(pos_inc);
    if (is_end) begin
      has_new      = 1'b1;
      new_tok.kind = kl_pkg::TOK_END;
      if (in_str) begin
        has_first = 1'b1;
        first_tok.kind    = kl_pkg::TOK_ERROR;
        first_tok.end_pos = kl_pkg::OUT_POS_W'(pos_inc);
      end else begin
        has_first = flush_valid;
      end
    end else if (in_str) begin
      has_new           = (cls == kl_pkg::CC_QUOTE);
      new_tok.kind      = kl_pkg::TOK_STRING;
      new_tok.start_pos = kl_pkg::OUT_POS_W'(tok_start);
    end else if (!ext_ident && !ext_num && !ext_op) begin
      has_first = flush_valid;
      case (cls)
        kl_pkg::CC_SINGLE: begin
          has_new      = 1'b1;
          new_tok.kind = kl_pkg::single_kind(text.char_code);
        end
        kl_pkg::CC_BAD: begin
          has_new      = 1'b1;
          new_tok.kind = kl_pkg::TOK_ERROR;
        end
        default: has_new = 1'b0;
      endcase
    end
  end

  assign push     = accept && (has_first || has_new);
  assign grp.tok0 = has_first ? first_tok : new_tok;
  assign grp.tok1 = new_tok;
  assign grp.two  = has_first && has_new;

  // next state
  always_comb begin
    pos_next       = pos;
    tok_start_next = tok_start;
    mode_next      = mode;
    kw_chars_next  = kw_chars;
    id_len_next    = id_len;
    op_chars_next  = op_chars;
    op_len_next    = op_len;
    if (accept) begin
      if (is_end) begin
        pos_next       = '0;
        tok_start_next = '0;
        mode_next      = kl_pkg::MODE_IDLE;
        kw_chars_next  = '0;
        id_len_next    = '0;
        op_chars_next  = '0;
        op_len_next    = '0;
      end else begin
        pos_next = pos_inc;
        if (in_str) begin
          if (cls == kl_pkg::CC_QUOTE) mode_next = kl_pkg::MODE_IDLE;
        end else if (ext_ident) begin
          if (id_len < 3'd4) begin
            kw_chars_next = {kw_chars[23:0], lc};
            id_len_next   = id_len + 3'd1;
          end else begin
            id_len_next = 3'd5;
          end
        end else if (ext_num) begin
          mode_next = kl_pkg::MODE_NUM;
        end else if (ext_op) begin
          if (op_len < 2'd2) begin
            op_chars_next = {op_chars[7:0], text.char_code};
            op_len_next   = op_len + 2'd1;
          end else begin
            op_len_next = 2'd3;
          end
        end else begin
          tok_start_next = pos;
          case (cls)
            kl_pkg::CC_TEXT: begin
              mode_next     = kl_pkg::MODE_IDENT;
              kw_chars_next = 32'(lc);
              id_len_next   = 3'd1;
            end
            kl_pkg::CC_DIGIT: mode_next = kl_pkg::MODE_NUM;
            kl_pkg::CC_QUOTE: mode_next = kl_pkg::MODE_STR;
            kl_pkg::CC_OPSYM: begin
              mode_next     = kl_pkg::MODE_OP;
              op_chars_next = 16'(text.char_code);
              op_len_next   = 2'd1;
            end
            default: mode_next = kl_pkg::MODE_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      tok_start <= '0;
      mode      <= kl_pkg::MODE_IDLE;
      kw_chars  <= '0;
      id_len    <= '0;
      op_chars  <= '0;
      op_len    <= '0;
    end else begin
      pos       <= pos_next;
      tok_start <= tok_start_next;
      mode      <= mode_next;
      kw_chars  <= kw_chars_next;
      id_len    <= id_len_next;
      op_chars  <= op_chars_next;
      op_len    <= op_len_next;
    end
  end

endmodule

### sv/kl_queue.sv
// ---------------------------------------------------------------------------
// kl_queue
// small fifo of token groups between front and back
// ---------------------------------------------------------------------------
module kl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kl_pkg::group_t  wr_grp,
  input  logic            pop,
  output kl_pkg::group_t  head,
  output logic            not_empty,
  output logic            full
);

  kl_pkg::group_t                entries [kl_pkg::QUEUE_DEPTH];
  logic [kl_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [kl_pkg::QPTR_W:0]       count;
  logic                          do_push, do_pop;

  assign full      = (count == (kl_pkg::QPTR_W + 1)'(kl_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == kl_pkg::QPTR_W'(kl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == kl_pkg::QPTR_W'(kl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/kl_back.sv
// ---------------------------------------------------------------------------
// kl_back
// splits token groups into single results behind an output register
// ---------------------------------------------------------------------------
module kl_back (
  input  logic            clk,
  input  logic            rst,
  input  kl_pkg::group_t  head,
  input  logic            q_valid,
  output logic            pop,
  kl_out_if.source        tokens
);

  kl_pkg::token_t out_tok, spare_tok;
  logic           out_valid, out_last, spare_valid;
  logic           out_free;

  assign out_free = !out_valid || tokens.ready;
  assign pop      = out_free && !spare_valid && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (out_free) begin
      if (spare_valid) begin
        out_tok     <= spare_tok;
        out_last    <= 1'b1;
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else if (q_valid) begin
        out_tok     <= head.tok0;
        out_last    <= !head.two;
        out_valid   <= 1'b1;
        spare_tok   <= head.tok1;
        spare_valid <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tokens.valid       = out_valid;
  assign tokens.token_kind  = out_tok.kind;
  assign tokens.start_pos   = out_tok.start_pos;
  assign tokens.end_pos     = out_tok.end_pos;
  assign tokens.last_of_run = out_last;

endmodule

### sv/keyword_lexer_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// keyword_lexer_tokenizer_unit
// streaming lexer: bytes in, tokens with start and end offsets out
// ---------------------------------------------------------------------------
//
// channel   dir   payload                                     notes
// text      in    kind, char_code                             one byte or end mark
// tokens    out   token_kind, start_pos, end_pos, last_of_run one token per request
//
// a byte request is taken every cycle while the group queue has room
// a byte gives zero, one or two tokens; the back end sends one token per cycle
// while tokens.ready is high, so sustained rate is one byte per cycle unless two-token bytes pile up
// a byte's first token passes through the queue and then the output register
// synchronous reset clears lexer state, queue pointers and output valid
// a stalled tokens channel fills the four-entry queue, then text.ready drops
//
`include "assert_macros.svh"

module keyword_lexer_tokenizer_unit (
  input  logic      clk,
  input  logic      rst,
  kl_in_if.sink     text,
  kl_out_if.source  tokens
);

  // groups leaving the front end
  kl_pkg::group_t front_grp;
  logic           front_push;

  // queue head feeding the back end
  kl_pkg::group_t q_head;
  logic           q_not_empty;
  logic           q_full;
  logic           back_pop;

  // front: classify each byte, track identifier / integer / string / operator
  // mode and collect the tokens that byte closes or opens
  kl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .q_full (q_full),
    .push   (front_push),
    .grp    (front_grp)
  );

  // decouples the byte side from token back-pressure
  kl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .wr_grp    (front_grp),
    .pop       (back_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // back: one token per cycle while tokens.ready is high, marks the last token of each byte
  kl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_valid (q_not_empty),
    .pop     (back_pop),
    .tokens  (tokens)
  );

  // first of two tokens leaves, the second is waiting in the spare register
  `KL_ASSERT_NEXT(a_second_follows, clk, rst, tokens.valid && tokens.ready && !tokens.last_of_run, tokens.valid, "second token of a byte missing")

  // the end token always closes its run
  `KL_ASSERT_SAME(a_end_is_last, clk, rst, tokens.valid && tokens.token_kind == kl_pkg::TOK_END, tokens.last_of_run, "end token not marked last")

  // an end mark always leaves a group in the queue
  `KL_ASSERT_NEXT(a_end_queued, clk, rst, text.valid && text.ready && text.kind == kl_pkg::KIND_END, q_not_empty, "end mark produced no group")

endmodule
